/* rtl/core/prefix_count_range_power_mod_defines.svh */
// Assertion macros used by the checker file of the prefix count block.
`ifndef PREFIX_COUNT_RANGE_POWER_MOD_DEFINES_SVH
`define PREFIX_COUNT_RANGE_POWER_MOD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PCRPM_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PCRPM_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pcrpm_pkg.sv */
// Types, sizes and constants of the prefix count range power block.
package pcrpm_pkg;

	// Bit string store
	localparam int unsigned MAX_LEN = 131072;
	localparam int unsigned POS_W   = 18;
	localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
	localparam int unsigned CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;
	localparam int unsigned IDX_W   = $clog2(LEN_W);

	// Modular arithmetic
	localparam int unsigned ANS_W = 30;
	localparam logic [ANS_W-1:0] MODULUS  = 30'd1000000007;
	localparam logic [31:0]      MODULUS2 = 32'd2000000014;
	// floor(2^60 / MODULUS) for Barrett reduction
	localparam logic [30:0] BARRETT_MU =
		31'(64'd1152921504606846976 / 64'd1000000007);

	// Opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic             bit_value;
		logic [POS_W-1:0] left_pos;
		logic [POS_W-1:0] right_pos;
	} cmd_t;

	typedef struct packed {
		logic [ANS_W-1:0] answer;
		logic             range_error;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_HI,
		ST_RD_LO,
		ST_COUNT,
		ST_MUL,
		ST_BAR1,
		ST_BAR2,
		ST_FIX,
		ST_DBL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_ONES,
		PH_ZEROS,
		PH_FINAL
	} phase_t;

endpackage

/* rtl/core/pcrpm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module pcrpm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/prefix_count_range_power_mod.sv */
// Prefix count range block: holds a bit string of up to MAX_LEN bits with the
// running count of ones per position, and answers range queries with
// ((2^ones - 1) * 2^zeros) mod 1000000007. Clear, append and unused opcodes
// do not stall the next command word. An invalid query goes straight to its
// result word. A valid query runs two reads of the count table, two 18-bit
// left-to-right powers of two and one final product. Every modular product
// runs through one shared 32x32 multiplier as a product, two Barrett passes
// and a correcting subtract; a set exponent bit adds a modular doubling step.
// No command word is taken while a query is in progress. A finished result
// word waits in the output register, and the next command word is taken
// meanwhile. The count table is not cleared after reset: only entries
// written since the last clear are read by a valid query.
module prefix_count_range_power_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  pcrpm_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output pcrpm_pkg::res_t   res
);

	import pcrpm_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  count_q;
	logic [IDX_W-1:0]  bit_idx_q;
	logic              res_valid_q;

	logic [POS_W-1:0]  left_q;
	logic [POS_W-1:0]  right_q;
	logic              err_q;
	logic [LEN_W-1:0]  cnt_hi_q;
	logic [LEN_W-1:0]  exp_q;
	logic [LEN_W-1:0]  zeros_q;
	logic [ANS_W-1:0]  acc_q;
	logic [ANS_W-1:0]  hi_q;
	logic [63:0]       prod_q;
	logic [31:0]       x_lo_q;
	res_t              res_q;

	logic              cmd_accept;
	logic              range_bad;
	logic              app_ok;
	logic [LEN_W-1:0]  app_count;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [LEN_W-1:0]  ram_rdata;
	logic [CMP_W-1:0]  rd_hi_addr;
	logic [CMP_W-1:0]  rd_lo_addr;
	logic [CMP_W-1:0]  total_ext;
	logic [LEN_W-1:0]  cnt_lo;
	logic [LEN_W-1:0]  ones_cnt;
	logic [LEN_W-1:0]  zeros_cnt;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [31:0]       fix_r;
	logic [32:0]       fix_m1;
	logic [32:0]       fix_m2;
	logic [ANS_W-1:0]  fix_val;
	logic [ANS_W:0]    dbl;
	logic [ANS_W+1:0]  dbl_m;
	logic [ANS_W-1:0]  dbl_val;
	logic [ANS_W-1:0]  step_val;
	logic [ANS_W-1:0]  hi_next;
	logic              bit_set;
	logic              last_bit;
	logic              advance;
	logic              res_load;

	// Handshake
	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// Query range check
	assign range_bad = (cmd.left_pos == '0) || (cmd.left_pos > cmd.right_pos) ||
		(CMP_W'(cmd.right_pos) > CMP_W'(len_q));

	// Append: next running count goes to the table at the current length
	assign app_ok    = (len_q < LEN_W'(MAX_LEN));
	assign app_count = count_q + LEN_W'(cmd.bit_value);
	assign ram_we    = cmd_accept && (cmd.opcode == OP_APPEND) && app_ok;

	// Table reads: count at right, then count before left
	assign rd_hi_addr = CMP_W'(right_q) - CMP_W'(1);
	assign rd_lo_addr = CMP_W'(left_q) - CMP_W'(2);
	assign ram_raddr  = (state_q == ST_RD_HI) ? rd_hi_addr[ADDR_W-1:0]
		: rd_lo_addr[ADDR_W-1:0];

	pcrpm_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_LEN)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q[ADDR_W-1:0]),
		.wdata(app_count),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Ones and zeros in the range
	assign cnt_lo    = (left_q == POS_W'(1)) ? '0 : ram_rdata;
	assign ones_cnt  = cnt_hi_q - cnt_lo;
	assign total_ext = CMP_W'(right_q) - CMP_W'(left_q) + CMP_W'(1);
	assign zeros_cnt = total_ext[LEN_W-1:0] - ones_cnt;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL: begin
				mul_a = 32'(acc_q);
				mul_b = (phase_q == PH_FINAL) ? 32'(hi_q) : 32'(acc_q);
			end
			ST_BAR1: begin
				mul_a = 32'(prod_q[59:29]);
				mul_b = 32'(BARRETT_MU);
			end
			ST_BAR2: begin
				mul_a = 32'(prod_q[61:31]);
				mul_b = 32'(MODULUS);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Barrett correction: remainder lies below three moduli
	assign fix_r   = x_lo_q - prod_q[31:0];
	assign fix_m1  = {1'b0, fix_r} - {1'b0, 32'(MODULUS)};
	assign fix_m2  = {1'b0, fix_r} - {1'b0, MODULUS2};
	assign fix_val = !fix_m2[32] ? fix_m2[ANS_W-1:0]
		: (!fix_m1[32] ? fix_m1[ANS_W-1:0] : fix_r[ANS_W-1:0]);

	// Modular doubling for a set exponent bit
	assign dbl     = {acc_q, 1'b0};
	assign dbl_m   = {1'b0, dbl} - (ANS_W + 2)'(MODULUS);
	assign dbl_val = dbl_m[ANS_W+1] ? dbl[ANS_W-1:0] : dbl_m[ANS_W-1:0];

	assign step_val = (state_q == ST_DBL) ? dbl_val : fix_val;
	assign hi_next  = (step_val == '0) ? (MODULUS - ANS_W'(1)) : (step_val - ANS_W'(1));

	// Exponent bit walk
	assign bit_set  = exp_q[bit_idx_q];
	assign last_bit = (bit_idx_q == '0);
	assign advance  = (state_q == ST_DBL) ||
		((state_q == ST_FIX) && (phase_q != PH_FINAL) && !bit_set);
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept && (cmd.opcode == OP_QUERY)) begin
					state_d = range_bad ? ST_DONE : ST_RD_HI;
				end
			end
			ST_RD_HI: state_d = ST_RD_LO;
			ST_RD_LO: state_d = ST_COUNT;
			ST_COUNT: state_d = ST_MUL;
			ST_MUL:   state_d = ST_BAR1;
			ST_BAR1:  state_d = ST_BAR2;
			ST_BAR2:  state_d = ST_FIX;
			ST_FIX: begin
				if (phase_q == PH_FINAL) begin
					state_d = ST_DONE;
				end else if (bit_set) begin
					state_d = ST_DBL;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DBL:   state_d = ST_MUL;
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_ONES;
			len_q       <= '0;
			count_q     <= '0;
			bit_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// String loading
			if (cmd_accept && (cmd.opcode == OP_CLEAR)) begin
				len_q   <= '0;
				count_q <= '0;
			end else if (ram_we) begin
				len_q   <= len_q + LEN_W'(1);
				count_q <= app_count;
			end

			// Power sequencing
			if (state_q == ST_COUNT) begin
				phase_q   <= PH_ONES;
				bit_idx_q <= IDX_W'(LEN_W - 1);
			end else if (advance) begin
				if (last_bit) begin
					if (phase_q == PH_ONES) begin
						phase_q   <= PH_ZEROS;
						bit_idx_q <= IDX_W'(LEN_W - 1);
					end else begin
						phase_q <= PH_FINAL;
					end
				end else begin
					bit_idx_q <= bit_idx_q - IDX_W'(1);
				end
			end

			// Result word valid
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_accept && (cmd.opcode == OP_QUERY)) begin
			left_q  <= cmd.left_pos;
			right_q <= cmd.right_pos;
			err_q   <= range_bad;
		end

		if (state_q == ST_RD_LO) begin
			cnt_hi_q <= ram_rdata;
		end

		if (state_q == ST_COUNT) begin
			exp_q   <= ones_cnt;
			zeros_q <= zeros_cnt;
			acc_q   <= ANS_W'(1);
		end

		// Modular product passes
		if ((state_q == ST_MUL) || (state_q == ST_BAR2)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_BAR1) begin
			x_lo_q <= prod_q[31:0];
			prod_q <= mul_p;
		end

		// First power done: keep 2^ones - 1, start on the zeros
		if (advance && last_bit && (phase_q == PH_ONES)) begin
			hi_q  <= hi_next;
			exp_q <= zeros_q;
			acc_q <= ANS_W'(1);
		end else if ((state_q == ST_FIX) || (state_q == ST_DBL)) begin
			acc_q <= step_val;
		end

		if (res_load) begin
			res_q.answer      <= err_q ? '0 : acc_q;
			res_q.range_error <= err_q;
		end
	end

endmodule

/* rtl/core/pcrpm_checker.sv */
// Port-level checker for the prefix count range block, bound to the top level.
`include "prefix_count_range_power_mod_defines.svh"

module pcrpm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input pcrpm_pkg::cmd_t cmd,
	input logic            res_valid,
	input logic            res_stall,
	input pcrpm_pkg::res_t res
);

	import pcrpm_pkg::*;

	// An error word carries a zero answer
	`PCRPM_ASSERT_IMPL(a_err_zero, clk, arst_n, res_valid && res.range_error, res.answer == '0, "error result word with non-zero answer")

	// Answers are fully reduced
	`PCRPM_ASSERT_IMPL(a_ans_reduced, clk, arst_n, res_valid && !res.range_error, res.answer < MODULUS, "answer not reduced modulo the prime")

	// A query holds off the next command word
	`PCRPM_ASSERT_NEXT(a_query_busy, clk, arst_n, cmd_valid && !cmd_stall && (cmd.opcode == OP_QUERY), cmd_stall, "command taken straight after a query")

	// Clear, append and unused opcodes do not stall the next command word
	`PCRPM_ASSERT_NEXT(a_load_free, clk, arst_n, cmd_valid && !cmd_stall && (cmd.opcode != OP_QUERY), !cmd_stall, "stall after a clear or append")

	// A stalled result word holds
	`PCRPM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result word changed")

endmodule

bind prefix_count_range_power_mod pcrpm_checker u_pcrpm_checker (.*);
